FILE: sv/catc_pkg.sv
// Package: shared constants, types and the microcode table of the card access table controller.
`timescale 1ns / 1ps

package catc_pkg;

    // Table geometry and field widths
    localparam int SLOTS    = 10;
    localparam int ID_BITS  = 32;
    localparam int CARD_W   = 32;
    localparam int OPC_W    = 2;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 4;
    localparam int SLOT_W   = 4;
    localparam int MODE_W   = 2;
    localparam int PTR_W    = $clog2(SLOTS);
    localparam int UPC_W    = 5;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [OPC_W-1:0]   t_opc;
    typedef logic [UPC_W-1:0]   t_upc;

    // Operating modes
    localparam t_mode MODE_READ   = MODE_W'(0);
    localparam t_mode MODE_MASTER = MODE_W'(1);
    localparam t_mode MODE_DELETE = MODE_W'(2);

    // Command codes
    localparam t_opc OPC_SCAN = OPC_W'(0);
    localparam t_opc OPC_ARM  = OPC_W'(1);
    localparam t_opc OPC_DEL  = OPC_W'(2);
    localparam t_opc OPC_OPEN = OPC_W'(3);

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 4'd0,
        ST_DENIED    = 4'd1,
        ST_ENROLLED  = 4'd2,
        ST_MASTER    = 4'd3,
        ST_CANCELLED = 4'd4,
        ST_ADDED     = 4'd5,
        ST_REMOVED   = 4'd6,
        ST_FULL      = 4'd7,
        ST_IGNORED   = 4'd8,
        ST_DELETED   = 4'd9,
        ST_ARMED     = 4'd10
    } t_status;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_OP_ARM,
        C_OP_DEL,
        C_OP_OPEN,
        C_MODE_DEL,
        C_MODE_MASTER,
        C_NOT_VALID,
        C_MATCH,
        C_STOP,
        C_DEL_BAD
    } t_cond;

    typedef enum logic [1:0] {SS_ZERO, SS_PTR, SS_IDX} t_slot_src;

    typedef enum logic [2:0] {MS_KEEP, MS_READ, MS_MASTER, MS_DELETE, MS_OPEN} t_mode_sel;

    typedef enum logic [1:0] {MO_NONE, MO_WRITE, MO_CLR_PTR, MO_CLR_IDX} t_mem_op;

    // Control word
    typedef struct packed {
        logic      wait_in;
        logic      inc;
        logic      loop;
        logic      emit;
        t_cond     cond;
        t_upc      target;
        t_status   status;
        t_slot_src slot_src;
        t_mode_sel mode_sel;
        t_mem_op   mem_op;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   go;
        logic   ptr_inc;
        t_uword uw;
    } t_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic  in_valid;
        logic  out_free;
        t_opc  opc;
        t_mode mode;
        logic  match;
        logic  valid_ptr;
        logic  ptr_last;
        logic  idx_bad;
    } t_flags;

    // Program addresses
    localparam t_upc A_FETCH   = UPC_W'(0);
    localparam t_upc A_D_ARM   = UPC_W'(1);
    localparam t_upc A_D_DEL   = UPC_W'(2);
    localparam t_upc A_D_OPEN  = UPC_W'(3);
    localparam t_upc A_S_DEL   = UPC_W'(4);
    localparam t_upc A_S_MSTR  = UPC_W'(5);
    localparam t_upc A_S_EMPTY = UPC_W'(6);
    localparam t_upc A_S_MCHK  = UPC_W'(7);
    localparam t_upc A_RWALK   = UPC_W'(8);
    localparam t_upc A_DENY    = UPC_W'(9);
    localparam t_upc A_GRANT   = UPC_W'(10);
    localparam t_upc A_ENROLL  = UPC_W'(11);
    localparam t_upc A_MSTR    = UPC_W'(12);
    localparam t_upc A_MSTART  = UPC_W'(13);
    localparam t_upc A_MWALK   = UPC_W'(14);
    localparam t_upc A_FULL    = UPC_W'(15);
    localparam t_upc A_DECIDE  = UPC_W'(16);
    localparam t_upc A_ADD     = UPC_W'(17);
    localparam t_upc A_REMOVE  = UPC_W'(18);
    localparam t_upc A_CANCEL  = UPC_W'(19);
    localparam t_upc A_ARM     = UPC_W'(20);
    localparam t_upc A_DELCHK  = UPC_W'(21);
    localparam t_upc A_DELETE  = UPC_W'(22);
    localparam t_upc A_OPEN    = UPC_W'(23);
    localparam t_upc A_IGN     = UPC_W'(24);

    // Branch step
    function automatic t_uword br(t_cond c, t_upc tgt, logic lp, logic inc);
        t_uword w;
        w          = '0;
        w.cond     = c;
        w.target   = tgt;
        w.loop     = lp;
        w.inc      = inc;
        w.status   = ST_GRANTED;
        w.slot_src = SS_ZERO;
        w.mode_sel = MS_KEEP;
        w.mem_op   = MO_NONE;
        return w;
    endfunction

    // Result step, always returns to fetch
    function automatic t_uword em(t_status st, t_slot_src src, t_mode_sel ms, t_mem_op mo);
        t_uword w;
        w          = br(C_ALWAYS, A_FETCH, 1'b0, 1'b0);
        w.emit     = 1'b1;
        w.status   = st;
        w.slot_src = src;
        w.mode_sel = ms;
        w.mem_op   = mo;
        return w;
    endfunction

    // Microcode ROM
    function automatic t_uword ucode(t_upc pc);
        t_uword w;
        case (pc)
            A_FETCH: begin
                w         = br(C_NEVER, A_FETCH, 1'b0, 1'b0);
                w.wait_in = 1'b1;
            end
            A_D_ARM:   w = br(C_OP_ARM,      A_ARM,    1'b0, 1'b0);
            A_D_DEL:   w = br(C_OP_DEL,      A_DELCHK, 1'b0, 1'b0);
            A_D_OPEN:  w = br(C_OP_OPEN,     A_OPEN,   1'b0, 1'b0);
            A_S_DEL:   w = br(C_MODE_DEL,    A_IGN,    1'b0, 1'b0);
            A_S_MSTR:  w = br(C_MODE_MASTER, A_MSTART, 1'b0, 1'b0);
            A_S_EMPTY: w = br(C_NOT_VALID,   A_ENROLL, 1'b0, 1'b0);
            A_S_MCHK:  w = br(C_MATCH,       A_MSTR,   1'b0, 1'b1);
            A_RWALK:   w = br(C_MATCH,       A_GRANT,  1'b1, 1'b0);
            A_DENY:    w = em(ST_DENIED,    SS_ZERO, MS_READ,   MO_NONE);
            A_GRANT:   w = em(ST_GRANTED,   SS_PTR,  MS_READ,   MO_NONE);
            A_ENROLL:  w = em(ST_ENROLLED,  SS_ZERO, MS_READ,   MO_WRITE);
            A_MSTR:    w = em(ST_MASTER,    SS_ZERO, MS_MASTER, MO_NONE);
            A_MSTART:  w = br(C_MATCH,       A_CANCEL, 1'b0, 1'b1);
            A_MWALK:   w = br(C_STOP,        A_DECIDE, 1'b1, 1'b0);
            A_FULL:    w = em(ST_FULL,      SS_ZERO, MS_READ,   MO_NONE);
            A_DECIDE:  w = br(C_MATCH,       A_REMOVE, 1'b0, 1'b0);
            A_ADD:     w = em(ST_ADDED,     SS_PTR,  MS_READ,   MO_WRITE);
            A_REMOVE:  w = em(ST_REMOVED,   SS_PTR,  MS_READ,   MO_CLR_PTR);
            A_CANCEL:  w = em(ST_CANCELLED, SS_ZERO, MS_READ,   MO_NONE);
            A_ARM:     w = em(ST_ARMED,     SS_ZERO, MS_DELETE, MO_NONE);
            A_DELCHK:  w = br(C_DEL_BAD,     A_IGN,    1'b0, 1'b0);
            A_DELETE:  w = em(ST_DELETED,   SS_IDX,  MS_READ,   MO_CLR_IDX);
            A_OPEN:    w = em(ST_GRANTED,   SS_ZERO, MS_OPEN,   MO_NONE);
            A_IGN:     w = em(ST_IGNORED,   SS_ZERO, MS_KEEP,   MO_NONE);
            default:   w = br(C_ALWAYS,      A_FETCH,  1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/catc_if.sv
// Interfaces: command channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface catc_in_if;
    logic                         valid;
    logic                         ready;
    logic [catc_pkg::OPC_W-1:0]   opcode;
    logic [catc_pkg::CARD_W-1:0]  card_id;
    logic [catc_pkg::IDX_W-1:0]   slot_index;

    modport source (output valid, opcode, card_id, slot_index, input ready);
    modport sink   (input valid, opcode, card_id, slot_index, output ready);
endinterface

interface catc_out_if;
    logic                          valid;
    logic                          ready;
    logic [catc_pkg::STATUS_W-1:0] status;
    logic [catc_pkg::SLOT_W-1:0]   slot;
    logic [catc_pkg::MODE_W-1:0]   mode_after;

    modport source (output valid, status, slot, mode_after, input ready);
    modport sink   (input valid, status, slot, mode_after, output ready);
endinterface

FILE: sv/catc_useq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`timescale 1ns / 1ps

module catc_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  catc_pkg::t_flags i_flags,
    output catc_pkg::t_ctl   o_ctl
);

    catc_pkg::t_upc   r_pc;
    catc_pkg::t_upc   n_pc;
    catc_pkg::t_uword w_uw;
    logic             w_cond;
    logic             w_stall;

    // Control word of the current step
    always_comb begin
        w_uw = catc_pkg::ucode(r_pc);
    end

    // Branch condition
    always_comb begin
        case (w_uw.cond)
            catc_pkg::C_NEVER:       w_cond = 1'b0;
            catc_pkg::C_ALWAYS:      w_cond = 1'b1;
            catc_pkg::C_OP_ARM:      w_cond = (i_flags.opc == catc_pkg::OPC_ARM);
            catc_pkg::C_OP_DEL:      w_cond = (i_flags.opc == catc_pkg::OPC_DEL);
            catc_pkg::C_OP_OPEN:     w_cond = (i_flags.opc == catc_pkg::OPC_OPEN);
            catc_pkg::C_MODE_DEL:    w_cond = (i_flags.mode == catc_pkg::MODE_DELETE);
            catc_pkg::C_MODE_MASTER: w_cond = (i_flags.mode == catc_pkg::MODE_MASTER);
            catc_pkg::C_NOT_VALID:   w_cond = !i_flags.valid_ptr;
            catc_pkg::C_MATCH:       w_cond = i_flags.match;
            catc_pkg::C_STOP:        w_cond = i_flags.match || !i_flags.valid_ptr;
            catc_pkg::C_DEL_BAD:     w_cond = i_flags.idx_bad;
            default:                 w_cond = 1'b0;
        endcase
    end

    // Hold on an empty input or a full result register
    assign w_stall = (w_uw.wait_in && !i_flags.in_valid) ||
                     (w_uw.emit && !i_flags.out_free);

    // Next step
    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_uw.target;
        end else if (w_uw.loop && !i_flags.ptr_last) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + catc_pkg::UPC_W'(1);
        end
    end

    // Controls to the datapath
    always_comb begin
        o_ctl.uw      = w_uw;
        o_ctl.go      = !w_stall;
        o_ctl.ptr_inc = !w_stall &&
                        (w_uw.inc || (w_uw.loop && !w_cond && !i_flags.ptr_last));
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= catc_pkg::A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Every result step goes back to fetch
    a_emit_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.go && w_uw.emit) |=> (r_pc == catc_pkg::A_FETCH))
        else $error("result step did not return to fetch");

    // A held step keeps its address
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ctl.go |=> $stable(r_pc))
        else $error("step counter moved during a hold");

endmodule

FILE: sv/catc_dp.sv
// Datapath: card table, valid bits, mode, walk pointer and result register.
`timescale 1ns / 1ps

module catc_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  catc_pkg::t_ctl   i_ctl,
    output catc_pkg::t_flags o_flags,
    catc_in_if.sink          i_in,
    catc_out_if.source       o_out
);

    catc_pkg::t_id                  r_slots [catc_pkg::SLOTS];
    logic [catc_pkg::SLOTS-1:0]     r_valid;
    catc_pkg::t_mode                r_mode;
    catc_pkg::t_ptr                 r_ptr;
    catc_pkg::t_opc                 r_opc;
    catc_pkg::t_id                  r_id;
    logic [catc_pkg::IDX_W-1:0]     r_idx;
    logic                           r_out_valid;
    catc_pkg::t_status              r_out_status;
    logic [catc_pkg::SLOT_W-1:0]    r_out_slot;
    catc_pkg::t_mode                r_out_mode;

    catc_pkg::t_id                  w_id;
    catc_pkg::t_mode                w_mode_new;
    catc_pkg::t_ptr                 w_idx_ptr;
    logic [catc_pkg::SLOT_W-1:0]    w_slot;
    logic                           w_accept;
    logic                           w_fire;

    assign w_accept  = i_ctl.go && i_ctl.uw.wait_in;
    assign w_fire    = i_ctl.go && i_ctl.uw.emit;
    assign w_idx_ptr = catc_pkg::PTR_W'(r_idx);

    // Card id trimmed or extended to the stored width
    if (catc_pkg::ID_BITS <= catc_pkg::CARD_W) begin : g_id_trim
        assign w_id = i_in.card_id[catc_pkg::ID_BITS-1:0];
    end else begin : g_id_ext
        assign w_id = catc_pkg::ID_BITS'(i_in.card_id);
    end

    assign i_in.ready = i_ctl.uw.wait_in;

    // Flags for the sequencer
    always_comb begin
        o_flags.in_valid  = i_in.valid;
        o_flags.out_free  = !r_out_valid || o_out.ready;
        o_flags.opc       = r_opc;
        o_flags.mode      = r_mode;
        o_flags.valid_ptr = r_valid[r_ptr];
        o_flags.match     = r_valid[r_ptr] && (r_slots[r_ptr] == r_id);
        o_flags.ptr_last  = (r_ptr == catc_pkg::PTR_W'(catc_pkg::SLOTS - 1));
        o_flags.idx_bad   = (r_mode != catc_pkg::MODE_DELETE) ||
                            (int'(r_idx) >= catc_pkg::SLOTS);
    end

    // Mode after the current result
    always_comb begin
        case (i_ctl.uw.mode_sel)
            catc_pkg::MS_KEEP:   w_mode_new = r_mode;
            catc_pkg::MS_READ:   w_mode_new = catc_pkg::MODE_READ;
            catc_pkg::MS_MASTER: w_mode_new = catc_pkg::MODE_MASTER;
            catc_pkg::MS_DELETE: w_mode_new = catc_pkg::MODE_DELETE;
            catc_pkg::MS_OPEN:   w_mode_new = (r_mode == catc_pkg::MODE_DELETE) ?
                                              catc_pkg::MODE_READ : r_mode;
            default:             w_mode_new = r_mode;
        endcase
    end

    // Reported slot
    always_comb begin
        case (i_ctl.uw.slot_src)
            catc_pkg::SS_ZERO: w_slot = '0;
            catc_pkg::SS_PTR:  w_slot = catc_pkg::SLOT_W'(r_ptr);
            catc_pkg::SS_IDX:  w_slot = catc_pkg::SLOT_W'(r_idx);
            default:           w_slot = '0;
        endcase
    end

    // Command capture and walk pointer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opc <= i_in.opcode;
            r_id  <= w_id;
            r_idx <= i_in.slot_index;
            r_ptr <= '0;
        end else if (i_ctl.ptr_inc) begin
            r_ptr <= r_ptr + catc_pkg::PTR_W'(1);
        end
    end

    // Card id store
    always_ff @(posedge i_clk) begin
        if (w_fire && i_ctl.uw.mem_op == catc_pkg::MO_WRITE) begin
            r_slots[r_ptr] <= r_id;
        end
    end

    // Valid bits and mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_mode  <= catc_pkg::MODE_READ;
        end else if (w_fire) begin
            r_mode <= w_mode_new;
            case (i_ctl.uw.mem_op)
                catc_pkg::MO_WRITE:   r_valid[r_ptr]     <= 1'b1;
                catc_pkg::MO_CLR_PTR: r_valid[r_ptr]     <= 1'b0;
                catc_pkg::MO_CLR_IDX: r_valid[w_idx_ptr] <= 1'b0;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= i_ctl.uw.status;
            r_out_slot   <= w_slot;
            r_out_mode   <= w_mode_new;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.slot       = r_out_slot;
    assign o_out.mode_after = r_out_mode;

    // A result step always leaves a result waiting
    a_fire_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("result step left no result");

    // Removing a card frees its slot
    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_ctl.uw.mem_op == catc_pkg::MO_CLR_PTR) |=> !r_valid[$past(r_ptr)])
        else $error("removed slot still valid");

    // Enrolling a master marks slot 0
    a_enroll_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_ctl.uw.status == catc_pkg::ST_ENROLLED) |=> r_valid[0])
        else $error("master slot not valid after enrollment");

endmodule

FILE: sv/card_access_table_controller_top.sv
// Top level of the card access table controller.
//
//  Channel  Direction  Payload                          Transfer
//  i_in     in         opcode, card_id, slot_index      valid & ready
//  o_out    out        status, slot, mode_after         valid & ready
//
// One command at a time; a microcoded sequencer walks the slots one per cycle.
// The shortest command is arm delete; the longest is a miss in read mode.
// The slot walk, one table entry per cycle, makes up most of the longest command.
// Reset (synchronous, active low) clears the valid bits, the mode and the result valid flag.
// A result waits in its register while the sink stalls; the next command is taken as soon as
// that result is loaded, and a result step holds only if the register is still occupied.
`timescale 1ns / 1ps

module card_access_table_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    catc_in_if.sink    i_in,
    catc_out_if.source o_out
);

    catc_pkg::t_ctl   w_ctl;
    catc_pkg::t_flags w_flags;

    // Control sequencer
    catc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // Table datapath
    catc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_flags (w_flags),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the card access table controller: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import catc_pkg::*;

    localparam int N_RANDOM    = 1875;  // random transfers that the block acts on
    localparam int POOL        = 8;
    localparam int HOLD_AT     = 700;   // results seen before the long sink hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;  // cycles with no transfer on either channel
    localparam int TAIL        = 30;    // wait after the drain, longer than the longest command
    localparam int N_DIR       = 25;

    typedef struct packed {
        t_opc              opcode;
        logic [CARD_W-1:0] card_id;
        logic [IDX_W-1:0]  slot_index;
    } cmd_t;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        t_mode             mode_after;
    } res_t;

    // Directed row; typed rows carry an expected result, the rest use the predictor
    typedef struct packed {
        t_opc              opcode;
        logic [CARD_W-1:0] card_id;
        logic [IDX_W-1:0]  slot_index;
        logic              typed;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        t_mode             mode_after;
    } row_t;

    localparam logic [CARD_W-1:0] MCARD = 32'hFFFF_FFFF;

    row_t dir_tab [N_DIR] = '{
        '{OPC_DEL,  32'h0,         4'd3,  1'b1, ST_IGNORED,   4'd0, MODE_READ},
        '{OPC_OPEN, 32'h0,         4'd0,  1'b1, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_ENROLLED,  4'd0, MODE_READ},
        '{OPC_SCAN, 32'h0,         4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_MASTER,    4'd0, MODE_MASTER},
        '{OPC_SCAN, 32'h0,         4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, 32'h0,         4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, 32'hA5A5_A5A5, 4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_MASTER,    4'd0, MODE_MASTER},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_CANCELLED, 4'd0, MODE_READ},
        '{OPC_ARM,  32'h0,         4'd0,  1'b1, ST_ARMED,     4'd0, MODE_DELETE},
        '{OPC_SCAN, 32'h0,         4'd0,  1'b1, ST_IGNORED,   4'd0, MODE_DELETE},
        '{OPC_DEL,  32'h0,         4'd15, 1'b1, ST_IGNORED,   4'd0, MODE_DELETE},
        '{OPC_DEL,  32'h0,         4'd10, 1'b1, ST_IGNORED,   4'd0, MODE_DELETE},
        '{OPC_OPEN, 32'h0,         4'd0,  1'b1, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_MASTER,    4'd0, MODE_MASTER},
        '{OPC_SCAN, 32'h0,         4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ},
        '{OPC_ARM,  32'h0,         4'd0,  1'b1, ST_ARMED,     4'd0, MODE_DELETE},
        '{OPC_DEL,  32'h0,         4'd9,  1'b1, ST_DELETED,   4'd9, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b1, ST_MASTER,    4'd0, MODE_MASTER},
        '{OPC_OPEN, 32'h0,         4'd0,  1'b1, ST_GRANTED,   4'd0, MODE_MASTER},
        '{OPC_ARM,  32'h0,         4'd0,  1'b1, ST_ARMED,     4'd0, MODE_DELETE},
        '{OPC_DEL,  32'h0,         4'd0,  1'b1, ST_DELETED,   4'd0, MODE_READ},
        '{OPC_SCAN, 32'h1234_5678, 4'd0,  1'b1, ST_ENROLLED,  4'd0, MODE_READ},
        '{OPC_SCAN, MCARD,         4'd0,  1'b0, ST_GRANTED,   4'd0, MODE_READ}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    catc_in_if  cmd_if ();
    catc_out_if res_if ();

    card_access_table_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // Shadow copy of the card table
    t_id               card_tab [SLOTS];
    bit                card_ok  [SLOTS];
    t_mode             cur_mode;
    logic [CARD_W-1:0] id_pool  [POOL];

    res_t pending_results [$];
    int   mismatch_cnt = 0;
    int   results_seen = 0;
    int   useful_cnt   = 0;
    bit   calm         = 1'b0;
    bit   held_off     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Expected result of one command; updates the shadow table and mode
    function automatic res_t access_predict(cmd_t c);
        res_t r;
        t_id  id;
        int   n;
        bit   done;
        id     = t_id'(c.card_id);
        r.slot = '0;
        done   = 1'b0;
        case (c.opcode)
            OPC_SCAN: begin
                if (cur_mode == MODE_DELETE) begin
                    r.status = ST_IGNORED;
                end else if (cur_mode == MODE_MASTER) begin
                    cur_mode = MODE_READ;
                    if (card_ok[0] && card_tab[0] == id) begin
                        r.status = ST_CANCELLED;
                    end else begin
                        // first slot that matches or is free decides
                        r.status = ST_FULL;
                        for (n = 1; n < SLOTS && !done; n++) begin
                            if (card_ok[n] && card_tab[n] == id) begin
                                card_ok[n] = 1'b0;
                                r.status   = ST_REMOVED;
                                r.slot     = SLOT_W'(n);
                                done       = 1'b1;
                            end else if (!card_ok[n]) begin
                                card_tab[n] = id;
                                card_ok[n]  = 1'b1;
                                r.status    = ST_ADDED;
                                r.slot      = SLOT_W'(n);
                                done        = 1'b1;
                            end
                        end
                    end
                end else begin
                    cur_mode = MODE_READ;
                    if (!card_ok[0]) begin
                        card_tab[0] = id;
                        card_ok[0]  = 1'b1;
                        r.status    = ST_ENROLLED;
                    end else if (card_tab[0] == id) begin
                        cur_mode = MODE_MASTER;
                        r.status = ST_MASTER;
                    end else begin
                        // lowest matching user slot wins
                        r.status = ST_DENIED;
                        for (n = SLOTS - 1; n >= 1; n--) begin
                            if (card_ok[n] && card_tab[n] == id) begin
                                r.status = ST_GRANTED;
                                r.slot   = SLOT_W'(n);
                            end
                        end
                    end
                end
            end
            OPC_ARM: begin
                cur_mode = MODE_DELETE;
                r.status = ST_ARMED;
            end
            OPC_DEL: begin
                if (cur_mode != MODE_DELETE || c.slot_index >= SLOTS) begin
                    r.status = ST_IGNORED;
                end else begin
                    card_ok[c.slot_index] = 1'b0;
                    cur_mode = MODE_READ;
                    r.status = ST_DELETED;
                    r.slot   = SLOT_W'(c.slot_index);
                end
            end
            default: begin
                if (cur_mode == MODE_DELETE) cur_mode = MODE_READ;
                r.status = ST_GRANTED;
            end
        endcase
        r.mode_after = cur_mode;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(t_opc op, logic [CARD_W-1:0] id, logic [IDX_W-1:0] idx);
        cmd_t c;
        c.opcode     = op;
        c.card_id    = id;
        c.slot_index = idx;
        return c;
    endfunction

    // Card for a scan: one held in the table, one from the pool, or a fresh one
    function automatic logic [CARD_W-1:0] pick_card();
        int held [$];
        int k;
        for (k = 1; k < SLOTS; k++) if (card_ok[k]) held.push_back(k);
        k = $urandom_range(0, 9);
        if (k < 4 && held.size() > 0) return card_tab[held[$urandom_range(0, held.size() - 1)]];
        if (k < 8) return id_pool[$urandom_range(0, POOL - 1)];
        return $urandom;
    endfunction

    function automatic logic [CARD_W-1:0] master_card();
        return card_ok[0] ? card_tab[0] : pick_card();
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command, wait for its transfer, record the expected result
    task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
        res_t r;
        bit   taken;
        int   gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= c.opcode;
        cmd_if.card_id    <= c.card_id;
        cmd_if.slot_index <= c.slot_index;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = cmd_if.ready;
            @(posedge i_clk);
        end
        r = access_predict(c);
        if (r.status != ST_IGNORED) useful_cnt++;
        pending_results.push_back(typed ? want : r);
    endtask

    // Result checker, sampled mid-cycle
    always @(negedge i_clk) begin
        res_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d slot %0d mode %0d", $time,
                         res_if.status, res_if.slot, res_if.mode_after);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, res_if.status);
                    mismatch_cnt++;
                end
                if (res_if.slot !== want.slot) begin
                    $display("%0t: slot mismatch: expected %0d, actual %0d", $time,
                             want.slot, res_if.slot);
                    mismatch_cnt++;
                end
                if (res_if.mode_after !== want.mode_after) begin
                    $display("%0t: mode mismatch: expected %0d, actual %0d", $time,
                             want.mode_after, res_if.mode_after);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Result sink: random stalls, one long hold-off to back up the block
    initial begin
        int span;
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= HOLD_AT) begin
                res_if.ready <= 1'b0;
                held_off = 1'b1;
                span     = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                span = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(15, 50);
            end else begin
                res_if.ready <= 1'b1;
                span = $urandom_range(1, 16);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // Watchdog: no transfer on either channel for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL card_access_table_controller_top");
        $finish;
    end

    // Stimulus
    initial begin
        int   i;
        int   k;
        res_t want;
        res_t none;
        cmd_if.valid      <= 1'b0;
        cmd_if.opcode     <= OPC_SCAN;
        cmd_if.card_id    <= '0;
        cmd_if.slot_index <= '0;
        none = '0;
        cur_mode = MODE_READ;
        for (i = 0; i < SLOTS; i++) card_ok[i] = 1'b0;
        for (i = 0; i < POOL; i++) id_pool[i] = $urandom;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < N_DIR; i++) begin
            want.status     = dir_tab[i].status;
            want.slot       = dir_tab[i].slot;
            want.mode_after = dir_tab[i].mode_after;
            send_cmd(mk_cmd(dir_tab[i].opcode, dir_tab[i].card_id, dir_tab[i].slot_index),
                     dir_tab[i].typed, want);
        end

        // random traffic, mostly well-formed enrollment and lookup sequences
        useful_cnt = 0;
        while (useful_cnt < N_RANDOM) begin
            calm = (useful_cnt >= 1000 && useful_cnt < 1200);
            if ($urandom_range(0, 49) == 0) id_pool[$urandom_range(0, POOL - 1)] = $urandom;
            k = $urandom_range(0, 99);
            if (k < 40) begin
                // master scan, then add / remove / cancel
                send_cmd(mk_cmd(OPC_SCAN, master_card(), IDX_W'($urandom)), 1'b0, none);
                send_cmd(mk_cmd(OPC_SCAN, ($urandom_range(0, 9) == 0) ? master_card()
                                                                      : pick_card(),
                                IDX_W'($urandom)), 1'b0, none);
            end else if (k < 65) begin
                send_cmd(mk_cmd(OPC_SCAN, pick_card(), IDX_W'($urandom)), 1'b0, none);
            end else if (k < 80) begin
                send_cmd(mk_cmd(OPC_ARM, $urandom, IDX_W'($urandom)), 1'b0, none);
                send_cmd(mk_cmd(OPC_DEL, $urandom,
                                ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(SLOTS, 15))
                                                            : IDX_W'($urandom_range(0, SLOTS - 1))),
                         1'b0, none);
            end else if (k < 88) begin
                send_cmd(mk_cmd(OPC_OPEN, $urandom, IDX_W'($urandom)), 1'b0, none);
            end else begin
                send_cmd(mk_cmd(t_opc'($urandom_range(0, 3)), $urandom, IDX_W'($urandom)),
                         1'b0, none);
            end
        end
        calm = 1'b0;
        cmd_if.valid <= 1'b0;

        // drain, then let any stray result show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS card_access_table_controller_top");
        end else begin
            $display("FAIL card_access_table_controller_top");
        end
        $finish;
    end

endmodule
